// File: rtl/core/i2c_master_transfer_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Concurrent check wrappers, clocked on clk and disabled while rst_n is low.
// The checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define I2CMS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CMS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Status codes, command and status encodings, item, result and state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // upper bound on segments per transfer
  localparam int MAX_SEGMENTS = 16;

  // controller status codes, master mode
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_REPSTART = 8'h10;
  localparam logic [7:0] ST_AW_ACK   = 8'h18;
  localparam logic [7:0] ST_AW_NACK  = 8'h20;
  localparam logic [7:0] ST_DW_ACK   = 8'h28;
  localparam logic [7:0] ST_DW_NACK  = 8'h30;
  localparam logic [7:0] ST_AR_ACK   = 8'h40;
  localparam logic [7:0] ST_AR_NACK  = 8'h48;
  localparam logic [7:0] ST_DR_ACK   = 8'h50;
  localparam logic [7:0] ST_DR_NACK  = 8'h58;
  // error codes, handled by the catch-all arm
  localparam logic [7:0] ST_ARB_LOST = 8'h38;
  localparam logic [7:0] ST_BUS_ERR  = 8'h00;

  // item action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SET_STA = 3'd1,
    OP_CLR_STA = 3'd2,
    OP_SET_STO = 3'd3,
    OP_SET_AA  = 3'd4,
    OP_CLR_AA  = 3'd5,
    OP_CLR_ALL = 3'd6,
    OP_CLR_GO  = 3'd7
  } ctrl_op_t;

  typedef enum logic [1:0] {
    XS_BUSY    = 2'd0,
    XS_SUCCESS = 2'd1,
    XS_NACK    = 2'd2,
    XS_ERROR   = 2'd3
  } xfer_status_t;

  typedef struct packed {
    logic        action;
    logic [4:0]  segment_count;
    logic        si_pending;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [6:0]  seg_addr;
    logic        seg_read;
    logic [15:0] seg_len;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    ctrl_op_t     ctrl_op;
    logic         data_write_valid;
    logic [7:0]   data_write_value;
    logic         store_valid;
    logic [3:0]   store_segment;
    logic [15:0]  store_index;
    logic [7:0]   store_value;
    logic [3:0]   segment_index;
    logic [15:0]  byte_index;
    xfer_status_t transfer_status;
    logic         clear_si;
  } result_t;

  typedef struct packed {
    logic [3:0]   cur_seg;
    logic [15:0]  cur_byte;
    logic [4:0]   seg_left;
    xfer_status_t status;
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cms_in_if.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer input channel
// Valid/ready channel carrying start requests and controller events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cms_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  segment_count;
  logic        si_pending;
  logic [7:0]  status_code;
  logic [7:0]  rx_byte;
  logic [6:0]  seg_addr;
  logic        seg_read;
  logic [15:0] seg_len;
  logic [7:0]  tx_byte;

  modport source (
    output valid, action, segment_count, si_pending, status_code, rx_byte,
           seg_addr, seg_read, seg_len, tx_byte,
    input  ready
  );

  modport sink (
    input  valid, action, segment_count, si_pending, status_code, rx_byte,
           seg_addr, seg_read, seg_len, tx_byte,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/i2cms_out_if.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer result channel
// Valid/ready channel carrying controller commands, stores and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cms_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  ctrl_op;
  logic        data_write_valid;
  logic [7:0]  data_write_value;
  logic        store_valid;
  logic [3:0]  store_segment;
  logic [15:0] store_index;
  logic [7:0]  store_value;
  logic [3:0]  segment_index;
  logic [15:0] byte_index;
  logic [1:0]  transfer_status;
  logic        clear_si;

  modport source (
    output valid, ctrl_op, data_write_valid, data_write_value, store_valid,
           store_segment, store_index, store_value, segment_index, byte_index,
           transfer_status, clear_si,
    input  ready
  );

  modport sink (
    input  valid, ctrl_op, data_write_valid, data_write_value, store_valid,
           store_segment, store_index, store_value, segment_index, byte_index,
           transfer_status, clear_si,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/i2cms_decode.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer decode
// Status-code decision logic: next sequencer state and result for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cms_decode (
  input  i2cms_pkg::item_t      item,
  input  i2cms_pkg::seq_state_t state_cur,
  output i2cms_pkg::seq_state_t state_nxt,
  output i2cms_pkg::result_t    result
);

  logic [4:0]  cnt_clip;
  logic [15:0] byte_inc;
  logic        byte_lt_len;
  logic        last_seg;
  logic        ack_last_cur;
  logic        ack_last_inc;

  // saturating byte increment for received data
  assign byte_inc     = (state_cur.cur_byte != 16'hFFFF) ? state_cur.cur_byte + 16'd1
                                                         : state_cur.cur_byte;
  assign byte_lt_len  = state_cur.cur_byte < item.seg_len;
  assign last_seg     = state_cur.seg_left <= 5'd1;
  // 17-bit compares: index 0xFFFF plus one never matches a length
  assign ack_last_cur = ({1'b0, state_cur.cur_byte} + 17'd1) == {1'b0, item.seg_len};
  assign ack_last_inc = ({1'b0, byte_inc} + 17'd1) == {1'b0, item.seg_len};

  always_comb begin
    cnt_clip = (item.segment_count == 5'd0) ? 5'd1 : item.segment_count;
    if (int'(cnt_clip) > i2cms_pkg::MAX_SEGMENTS) begin
      cnt_clip = 5'(i2cms_pkg::MAX_SEGMENTS);
    end
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '0;

    if (item.action == i2cms_pkg::ACT_START) begin
      state_nxt.cur_seg  = 4'd0;
      state_nxt.cur_byte = 16'd0;
      state_nxt.seg_left = cnt_clip;
      state_nxt.status   = i2cms_pkg::XS_BUSY;
      result.ctrl_op     = i2cms_pkg::OP_CLR_GO;
    end else if (item.si_pending) begin
      result.clear_si = 1'b1;
      unique case (item.status_code) inside
        i2cms_pkg::ST_START, i2cms_pkg::ST_REPSTART: begin
          result.ctrl_op          = i2cms_pkg::OP_CLR_STA;
          result.data_write_valid = 1'b1;
          result.data_write_value = {item.seg_addr, item.seg_read};
        end
        i2cms_pkg::ST_AW_NACK, i2cms_pkg::ST_AR_NACK, i2cms_pkg::ST_DW_NACK: begin
          result.ctrl_op   = i2cms_pkg::OP_SET_STO;
          state_nxt.status = i2cms_pkg::XS_NACK;
        end
        i2cms_pkg::ST_AW_ACK, i2cms_pkg::ST_DW_ACK: begin
          if (byte_lt_len) begin
            result.data_write_valid = 1'b1;
            result.data_write_value = item.tx_byte;
            state_nxt.cur_byte      = state_cur.cur_byte + 16'd1;
          end else if (last_seg) begin
            state_nxt.seg_left = 5'd0;
            state_nxt.status   = i2cms_pkg::XS_SUCCESS;
            result.ctrl_op     = i2cms_pkg::OP_SET_STO;
          end else begin
            state_nxt.seg_left = state_cur.seg_left - 5'd1;
            state_nxt.cur_seg  = state_cur.cur_seg + 4'd1;
            state_nxt.cur_byte = 16'd0;
            result.ctrl_op     = i2cms_pkg::OP_SET_STA;
          end
        end
        i2cms_pkg::ST_AR_ACK: begin
          result.ctrl_op = ack_last_cur ? i2cms_pkg::OP_CLR_AA : i2cms_pkg::OP_SET_AA;
        end
        i2cms_pkg::ST_DR_ACK: begin
          result.store_valid   = 1'b1;
          result.store_segment = state_cur.cur_seg;
          result.store_index   = state_cur.cur_byte;
          result.store_value   = item.rx_byte;
          state_nxt.cur_byte   = byte_inc;
          result.ctrl_op = ack_last_inc ? i2cms_pkg::OP_CLR_AA : i2cms_pkg::OP_SET_AA;
        end
        i2cms_pkg::ST_DR_NACK: begin
          result.store_valid   = 1'b1;
          result.store_segment = state_cur.cur_seg;
          result.store_index   = state_cur.cur_byte;
          result.store_value   = item.rx_byte;
          if (last_seg) begin
            state_nxt.cur_byte = byte_inc;
            state_nxt.seg_left = 5'd0;
            state_nxt.status   = i2cms_pkg::XS_SUCCESS;
            result.ctrl_op     = i2cms_pkg::OP_SET_STO;
          end else begin
            state_nxt.seg_left = state_cur.seg_left - 5'd1;
            state_nxt.cur_seg  = state_cur.cur_seg + 4'd1;
            state_nxt.cur_byte = 16'd0;
            result.ctrl_op     = i2cms_pkg::OP_SET_STA;
          end
        end
        default: begin
          // bus error, arbitration lost, unlisted codes
          result.ctrl_op   = i2cms_pkg::OP_CLR_ALL;
          state_nxt.status = i2cms_pkg::XS_ERROR;
        end
      endcase
    end

    result.segment_index   = state_nxt.cur_seg;
    result.byte_index      = state_nxt.cur_byte;
    result.transfer_status = state_nxt.status;
  end

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns serial controller status codes into controller commands, data
// register writes, received-byte stores and transfer status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one item per start request (action 0) or controller event
//            (action 1). An event with si_pending low is a no-op that still
//            yields a result with ctrl_op none and clear_si low.
//   out_ch - exactly one result item per input item, in order.
// Timing:
//   The input register takes the item at the accepting edge, the decode
//   logic works on it, and the result register loads the decoded result
//   once its slot is free. Throughput is one item per cycle while
//   out_ch.ready stays high; the only loop is the 16-bit index/segment
//   state update, which closes through the decode block.
// Stall:
//   When out_ch.ready is low the result register holds, the input register
//   fills, and in_ch.ready drops until the result is taken. Nothing is lost.
// Reset (rst_n low, synchronous):
//   Both channels go empty, segment and byte index clear, segments left
//   clears and the status reads busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_transfer_sequencer_macros.svh"

module i2c_master_transfer_sequencer (
  input  wire         clk,
  input  wire         rst_n,
  i2cms_in_if.sink    in_ch,
  i2cms_out_if.source out_ch
);

  // input register
  logic                  in_valid_r;
  i2cms_pkg::item_t      item_r;
  // sequencer state
  i2cms_pkg::seq_state_t state_r;
  i2cms_pkg::seq_state_t state_nxt;
  // result register
  logic                  out_valid_r;
  i2cms_pkg::result_t    res_r;
  i2cms_pkg::result_t    res_nxt;

  logic                  advance;
  logic                  in_take;

  // move the held item into the result register when that slot frees up
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action        <= in_ch.action;
      item_r.segment_count <= in_ch.segment_count;
      item_r.si_pending    <= in_ch.si_pending;
      item_r.status_code   <= in_ch.status_code;
      item_r.rx_byte       <= in_ch.rx_byte;
      item_r.seg_addr      <= in_ch.seg_addr;
      item_r.seg_read      <= in_ch.seg_read;
      item_r.seg_len       <= in_ch.seg_len;
      item_r.tx_byte       <= in_ch.tx_byte;
    end
  end

  i2cms_decode u_decode (
    .item      (item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // state commits together with the result it produced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.ctrl_op          = res_r.ctrl_op;
  assign out_ch.data_write_valid = res_r.data_write_valid;
  assign out_ch.data_write_value = res_r.data_write_value;
  assign out_ch.store_valid      = res_r.store_valid;
  assign out_ch.store_segment    = res_r.store_segment;
  assign out_ch.store_index      = res_r.store_index;
  assign out_ch.store_value      = res_r.store_value;
  assign out_ch.segment_index    = res_r.segment_index;
  assign out_ch.byte_index       = res_r.byte_index;
  assign out_ch.transfer_status  = res_r.transfer_status;
  assign out_ch.clear_si         = res_r.clear_si;

  // checks
  `I2CMS_ASSERT_NEXT(a_adv_loads_out, advance, out_valid_r, "advance did not load result")
  `I2CMS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_r), "state moved without advance")
  `I2CMS_ASSERT_NEXT(a_in_hold, in_valid_r && out_valid_r && !out_ch.ready,
                     in_valid_r && $stable(item_r), "held item lost during stall")
  `I2CMS_ASSERT_IMPLY(a_done_empty, state_r.status == i2cms_pkg::XS_SUCCESS,
                      state_r.seg_left == 5'd0, "success with segments left")
  `I2CMS_ASSERT_IMPLY(a_left_max, 1'b1,
                      int'(state_r.seg_left) <= i2cms_pkg::MAX_SEGMENTS,
                      "segments left above maximum")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives start requests and controller events into the sequencer. A local
// model of the status-code decoder predicts one command item per input
// item, and every command item that comes back is checked field by field.
// Both channels idle in random bursts, and the sender waits for the
// sequencer to drain at least once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import i2cms_pkg::*;

  // roughly 5x the slowest legal run: ~1.9k items, each behind up to
  // 7 idle cycles on the sender side and 7 stall cycles on the receiver side
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned STIM_ITEMS  = 1850;
  // the tail of the run, in items, where neither side idles
  localparam int unsigned CALM_TAIL   = 200;

  // one queued input item and the idle cycles the sender spends ahead of it
  typedef struct {
    item_t       it;
    int unsigned gap;
    bit          drain;   // hold the item until every command has come back
  } bus_event_t;

  logic clk;
  logic rst_n;

  i2cms_in_if  in_ch ();
  i2cms_out_if out_ch ();

  i2c_master_transfer_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bus_event_t  pending_events[$];
  result_t     expected_cmds[$];
  int unsigned stim_total;
  bit          sender_gaps;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Transfer model: segment/byte pointers, segments still to run, status
  // --------------------------------------------------------------------------
  logic [3:0]   seq_seg;
  logic [15:0]  seq_byte;
  logic [4:0]   seq_left;
  xfer_status_t seq_status;

  // Segment finished: stop on the last one, else repeated start into the next.
  // seq_left never wraps below zero.
  function automatic ctrl_op_t close_segment();
    if (seq_left <= 5'd1) begin
      seq_left   = 5'd0;
      seq_status = XS_SUCCESS;
      return OP_SET_STO;
    end
    seq_left = seq_left - 5'd1;
    seq_seg  = seq_seg + 4'd1;
    seq_byte = 16'd0;
    return OP_SET_STA;
  endfunction

  // NACK only the last byte of a read; done in 17 bits so that a zero
  // length or a saturated index never counts as the last byte
  function automatic ctrl_op_t ack_for_next(logic [15:0] len);
    return ({1'b0, seq_byte} + 17'd1 == {1'b0, len}) ? OP_CLR_AA : OP_SET_AA;
  endfunction

  // received byte goes to the buffer; index saturates at 0xFFFF
  function automatic void log_received(inout result_t r, input logic [7:0] v);
    r.store_valid   = 1'b1;
    r.store_segment = seq_seg;
    r.store_index   = seq_byte;
    r.store_value   = v;
    if (seq_byte != 16'hFFFF) seq_byte = seq_byte + 16'd1;
  endfunction

  function automatic result_t sequence_step(item_t it);
    result_t    r;
    logic [4:0] n;
    r = '0;
    r.ctrl_op = OP_NONE;
    r.transfer_status = XS_BUSY;
    if (it.action == ACT_START) begin
      // zero segments means one, anything over the maximum saturates
      n = it.segment_count;
      if (n == 5'd0) n = 5'd1;
      if (n > MAX_SEGMENTS) n = 5'(MAX_SEGMENTS);
      seq_seg    = 4'd0;
      seq_byte   = 16'd0;
      seq_left   = n;
      seq_status = XS_BUSY;
      r.ctrl_op  = OP_CLR_GO;
    end else if (it.si_pending) begin
      r.clear_si = 1'b1;
      case (it.status_code)
        ST_START, ST_REPSTART: begin
          r.ctrl_op          = OP_CLR_STA;
          r.data_write_valid = 1'b1;
          r.data_write_value = {it.seg_addr, it.seg_read};
        end
        ST_AW_NACK, ST_AR_NACK, ST_DW_NACK: begin
          r.ctrl_op  = OP_SET_STO;
          seq_status = XS_NACK;
        end
        ST_AW_ACK, ST_DW_ACK: begin
          if (seq_byte < it.seg_len) begin
            r.data_write_valid = 1'b1;
            r.data_write_value = it.tx_byte;
            seq_byte = seq_byte + 16'd1;
          end else begin
            r.ctrl_op = close_segment();
          end
        end
        ST_AR_ACK: r.ctrl_op = ack_for_next(it.seg_len);
        ST_DR_ACK: begin
          log_received(r, it.rx_byte);
          r.ctrl_op = ack_for_next(it.seg_len);
        end
        ST_DR_NACK: begin
          log_received(r, it.rx_byte);
          r.ctrl_op = close_segment();
        end
        // bus error, lost arbitration and any code not listed
        default: begin
          r.ctrl_op  = OP_CLR_ALL;
          seq_status = XS_ERROR;
        end
      endcase
    end
    r.segment_index   = seq_seg;
    r.byte_index      = seq_byte;
    r.transfer_status = seq_status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------
  function automatic item_t make_event(logic [7:0] code, logic [6:0] addr, logic rd,
                                       logic [15:0] len);
    item_t it;
    it.action        = ACT_EVENT;
    it.segment_count = 5'($urandom);
    it.si_pending    = 1'b1;
    it.status_code   = code;
    it.rx_byte       = 8'($urandom);
    it.seg_addr      = addr;
    it.seg_read      = rd;
    it.seg_len       = len;
    it.tx_byte       = 8'($urandom);
    return it;
  endfunction

  // event fields on a start item are don't-care, so they are random
  function automatic item_t make_start(logic [4:0] count);
    item_t it;
    it = make_event(8'($urandom), 7'($urandom), 1'($urandom), 16'($urandom));
    it.action        = ACT_START;
    it.segment_count = count;
    it.si_pending    = 1'($urandom);
    return it;
  endfunction

  // Sender idling follows the item position: no gaps, rare bursts, frequent
  // bursts, in turn, so gaps land on every stage of a transfer.
  task automatic queue_item(item_t it, bit drain);
    bus_event_t  e;
    int unsigned mode;
    e.it    = it;
    e.drain = drain;
    e.gap   = 0;
    mode = (pending_events.size() / 120) % 3;
    if (sender_gaps && mode != 0 && $urandom_range(0, (mode == 1) ? 11 : 2) == 0)
      e.gap = $urandom_range(1, 7);
    pending_events.push_back(e);
  endtask

  // no-op event: si_pending low, everything else random
  task automatic queue_idle_event();
    item_t it;
    it = make_event(8'($urandom), 7'($urandom), 1'($urandom), 16'($urandom));
    it.si_pending = 1'b0;
    queue_item(it, 1'b0);
  endtask

  // Occasionally break a transfer: NACK, lost arbitration or an arbitrary code.
  task automatic maybe_break(logic [6:0] addr, logic rd, logic [15:0] len,
                             output bit broke);
    logic [7:0] code;
    broke = 1'b0;
    if ($urandom_range(0, 14) == 0) queue_idle_event();
    if ($urandom_range(0, 39) != 0) return;
    case ($urandom_range(0, 4))
      0: code = ST_AW_NACK;
      1: code = ST_DW_NACK;
      2: code = ST_AR_NACK;
      3: code = ST_ARB_LOST;
      default: code = 8'($urandom);
    endcase
    queue_item(make_event(code, addr, rd, len), 1'b0);
    broke = 1'b1;
  endtask

  // A well-formed transfer with random content: start, then per segment the
  // (repeated) start, the address ack and the data phase.
  task automatic queue_transfer();
    int unsigned n, segs, nb;
    logic [6:0]  addr;
    logic        rd;
    logic [15:0] len;
    bit          broke;
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(0, 31);
      1, 2:    n = $urandom_range(5, 16);
      default: n = $urandom_range(1, 4);
    endcase
    queue_item(make_start(5'(n)), $urandom_range(0, 24) == 0);
    segs = (n == 0) ? 1 : ((n > MAX_SEGMENTS) ? MAX_SEGMENTS : n);
    for (int s = 0; s < segs; s++) begin
      addr = 7'($urandom);
      rd   = 1'($urandom);
      len  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      // long segments only move a few bytes before they are cut off
      nb = (len > 16'd12) ? $urandom_range(0, 12) : len;
      queue_item(make_event((s == 0) ? ST_START : ST_REPSTART, addr, rd, len), 1'b0);
      maybe_break(addr, rd, len, broke);
      if (broke) return;
      if (!rd) begin
        // address ack writes byte 0 or ends an empty segment; the ack after the last byte ends the segment
        queue_item(make_event(ST_AW_ACK, addr, rd, len), 1'b0);
        for (int k = 0; k < nb; k++) begin
          maybe_break(addr, rd, len, broke);
          if (broke) return;
          queue_item(make_event(ST_DW_ACK, addr, rd, len), 1'b0);
        end
        if (nb < len) begin
          queue_item(make_event(ST_DW_NACK, addr, rd, len), 1'b0);
          return;
        end
      end else begin
        queue_item(make_event(ST_AR_ACK, addr, rd, len), 1'b0);
        for (int k = 1; k < nb; k++) begin
          maybe_break(addr, rd, len, broke);
          if (broke) return;
          queue_item(make_event(ST_DR_ACK, addr, rd, len), 1'b0);
        end
        queue_item(make_event(ST_DR_NACK, addr, rd, len), 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random transfers
  // --------------------------------------------------------------------------
  initial begin
    item_t       it;
    logic [63:0] raw;
    sender_gaps = 1'b0;

    // no-op event before any transfer
    queue_idle_event();
    // count 0 acts as one segment; read with zero length always acks
    queue_item(make_start(5'd0), 1'b0);
    queue_item(make_event(ST_START, 7'h7F, 1'b1, 16'd0), 1'b0);
    queue_item(make_event(ST_AR_ACK, 7'h7F, 1'b1, 16'd0), 1'b0);
    it = make_event(ST_DR_ACK, 7'h7F, 1'b1, 16'd0);
    it.rx_byte = 8'hFF;
    queue_item(it, 1'b0);
    it = make_event(ST_DR_NACK, 7'h7F, 1'b1, 16'd0);
    it.rx_byte = 8'h00;
    queue_item(it, 1'b0);
    // event after the transfer completed still changes the status
    queue_item(make_event(ST_DW_NACK, 7'h00, 1'b0, 16'd0), 1'b0);
    // count 31 saturates at the maximum; sender drains first
    queue_item(make_start(5'd31), 1'b1);
    queue_item(make_event(ST_REPSTART, 7'h00, 1'b0, 16'd0), 1'b0);
    queue_item(make_event(ST_AW_ACK, 7'h00, 1'b0, 16'd0), 1'b0);
    queue_item(make_event(ST_START, 7'h55, 1'b0, 16'd1), 1'b0);
    it = make_event(ST_AW_ACK, 7'h55, 1'b0, 16'd1);
    it.tx_byte = 8'hFF;
    queue_item(it, 1'b0);
    it = make_event(ST_DW_ACK, 7'h55, 1'b0, 16'd1);
    it.tx_byte = 8'h00;
    queue_item(it, 1'b0);
    queue_item(make_event(ST_AW_NACK, 7'h2A, 1'b0, 16'd0), 1'b0);
    // one-byte read: the address ack already NACKs the coming byte
    queue_item(make_start(5'd17), 1'b0);
    queue_item(make_event(ST_START, 7'h2A, 1'b1, 16'd1), 1'b0);
    queue_item(make_event(ST_AR_ACK, 7'h2A, 1'b1, 16'd1), 1'b0);
    queue_item(make_event(ST_AR_NACK, 7'h2A, 1'b1, 16'd1), 1'b0);
    // codes for the catch-all arm: bus error, lost arbitration, all ones
    queue_item(make_start(5'd1), 1'b0);
    queue_item(make_event(ST_BUS_ERR, 7'h01, 1'b0, 16'd0), 1'b0);
    queue_item(make_event(ST_ARB_LOST, 7'h01, 1'b0, 16'd0), 1'b0);
    queue_item(make_event(8'hFF, 7'h01, 1'b0, 16'd0), 1'b0);
    queue_item(make_start(5'd16), 1'b0);
    queue_item(make_start(5'd15), 1'b0);
    queue_item(make_event(ST_AW_ACK, 7'h01, 1'b0, 16'hFFFF), 1'b0);

    // random part: mostly well-formed transfers, some fully random items
    sender_gaps = 1'b1;
    while (pending_events.size() < STIM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          raw = {$urandom, $urandom};
          queue_item(item_t'(raw[$bits(item_t)-1:0]), 1'b0);
        end
      end else begin
        queue_transfer();
      end
    end

    // no sender idling at the end of the run
    for (int i = pending_events.size() - CALM_TAIL; i < pending_events.size(); i++)
      pending_events[i].gap = 0;
    stim_total = pending_events.size();
  end

  // --------------------------------------------------------------------------
  // Clock, reset, known input values from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_START;
    in_ch.segment_count = '0;
    in_ch.si_pending    = 1'b0;
    in_ch.status_code   = '0;
    in_ch.rx_byte       = '0;
    in_ch.seg_addr      = '0;
    in_ch.seg_read      = 1'b0;
    in_ch.seg_len       = '0;
    in_ch.tx_byte       = '0;
    out_ch.ready        = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: presents queued items, predicts each one as it is accepted
  // --------------------------------------------------------------------------
  bit          drv_loaded;
  bus_event_t  drv_next;
  int unsigned drv_gap;

  always @(posedge clk) begin : drive_items
    logic  next_valid;
    item_t taken;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_loaded  = 1'b0;
      drv_gap     = 0;
      // model state after reset
      seq_seg     = 4'd0;
      seq_byte    = 16'd0;
      seq_left    = 5'd0;
      seq_status  = XS_BUSY;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        // the fields as they stood at this edge are the accepted item
        taken.action        = in_ch.action;
        taken.segment_count = in_ch.segment_count;
        taken.si_pending    = in_ch.si_pending;
        taken.status_code   = in_ch.status_code;
        taken.rx_byte       = in_ch.rx_byte;
        taken.seg_addr      = in_ch.seg_addr;
        taken.seg_read      = in_ch.seg_read;
        taken.seg_len       = in_ch.seg_len;
        taken.tx_byte       = in_ch.tx_byte;
        expected_cmds.push_back(sequence_step(taken));
        items_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (!drv_loaded && pending_events.size() != 0) begin
          drv_next   = pending_events.pop_front();
          drv_loaded = 1'b1;
          drv_gap    = drv_next.gap;
        end
        if (drv_loaded) begin
          if (drv_gap != 0) begin
            drv_gap--;
          end else if (!drv_next.drain || expected_cmds.size() == 0) begin
            in_ch.action        <= drv_next.it.action;
            in_ch.segment_count <= drv_next.it.segment_count;
            in_ch.si_pending    <= drv_next.it.si_pending;
            in_ch.status_code   <= drv_next.it.status_code;
            in_ch.rx_byte       <= drv_next.it.rx_byte;
            in_ch.seg_addr      <= drv_next.it.seg_addr;
            in_ch.seg_read      <= drv_next.it.seg_read;
            in_ch.seg_len       <= drv_next.it.seg_len;
            in_ch.tx_byte       <= drv_next.it.tx_byte;
            next_valid = 1'b1;
            drv_loaded = 1'b0;
          end
        end
      end
      // single assignment per edge keeps back-to-back valid solid
      in_ch.valid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each command item against the oldest prediction and
  // throttles ready in bursts
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  int unsigned stall_left;

  always @(posedge clk) begin : check_cmds
    result_t     want;
    logic        next_ready;
    int unsigned mode;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("command item with no input item outstanding");
          error_count++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("ctrl_op", want.ctrl_op, out_ch.ctrl_op);
          check_field("data_write_valid", want.data_write_valid, out_ch.data_write_valid);
          check_field("data_write_value", want.data_write_value, out_ch.data_write_value);
          check_field("store_valid", want.store_valid, out_ch.store_valid);
          check_field("store_segment", want.store_segment, out_ch.store_segment);
          check_field("store_index", want.store_index, out_ch.store_index);
          check_field("store_value", want.store_value, out_ch.store_value);
          check_field("segment_index", want.segment_index, out_ch.segment_index);
          check_field("byte_index", want.byte_index, out_ch.byte_index);
          check_field("transfer_status", want.transfer_status, out_ch.transfer_status);
          check_field("clear_si", want.clear_si, out_ch.clear_si);
        end
        results_seen++;
      end
      // stall odds cycle with the result count; none near the end
      mode = (results_seen / 256) % 3;
      if (stall_left != 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (results_seen + CALM_TAIL < stim_total && mode != 0 &&
                   $urandom_range(0, (mode == 1) ? 15 : 3) == 0) begin
        stall_left = $urandom_range(0, 6);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Reset, then wait for every item to go in and every command to come out
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (items_accepted < stim_total) @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    // input register, then result register; any stray command item shows up well within this wait
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
